FILE: rtl/bsm_pkg.sv
`default_nettype none
package bsm_pkg;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] address;
    logic [7:0]  value;
    logic [2:0]  counter_clocks;
  } in_t;

  typedef struct packed {
    logic [7:0] bank_number;
    logic       in_prg_ram;
    logic       mirror_horizontal;
    logic       irq_line;
  } out_t;

  typedef enum logic [1:0] {
    REQ_WRITE    = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_CPU_XLAT = 2'd2,
    REQ_PAT_XLAT = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    WR_NONE,
    WR_BANK_SEL,
    WR_BANK_DATA,
    WR_MIRROR,
    WR_RELOAD_VAL,
    WR_RELOAD,
    WR_IRQ_OFF,
    WR_IRQ_ON
  } wr_t;

  // Classified word handed from the front end to the execution side.
  typedef struct packed {
    req_t       op;
    wr_t        wr;
    logic [2:0] slot;     // prg slot in [1:0], or 1 KB pattern slot
    logic       prg_win;  // CPU address at 8000 and above
    logic       ram_win;  // CPU address in 6000-7FFF
    logic [7:0] value;
    logic [2:0] clocks;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_TICK
  } bk_state_t;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int CFG_DATA_W = 6;
  localparam logic [1:0] CFG_PRG_BANKS   = 2'd0;
  localparam logic [1:0] CFG_HAS_PRG_RAM = 2'd1;
  localparam logic [1:0] CFG_FOUR_SCREEN = 2'd2;

  localparam logic [5:0] PRG_BANKS_RESET = 6'd16;

endpackage
`default_nettype wire

FILE: rtl/bank_switch_mapper_scanline_irq_unit.sv
`default_nettype none
// Cartridge bank mapper with a scanline interrupt counter. Each input word is a
// register write, a scanline tick or an address translation, and yields one
// result word carrying the bank, the work RAM hit, the mirroring and the IRQ
// level after that word. A front stage decodes the word and hands it through
// a two-entry queue to the execution stage, which owns all mapper state. Writes
// and translations are taken there only while the output register is free,
// and their result is registered as they are taken. A scanline tick is taken,
// then steps the IRQ counter once per counter clock, and then emits its result
// once the output register is free. Configuration is written through
// cfg_we/cfg_index/cfg_data while the block is idle; index 0 is the program
// size in 16 KB units, 1 the work RAM present flag, 2 the four-screen lock.
module bank_switch_mapper_scanline_irq_unit (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire bsm_pkg::in_t                      in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output bsm_pkg::out_t                          out_data,
  input  wire logic                              cfg_we,
  input  wire logic [1:0]                        cfg_index,
  input  wire logic [bsm_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import bsm_pkg::*;

  logic [5:0] prg_banks_16k;
  logic       has_prg_ram;
  logic       four_screen;

  logic       f_valid, f_ready;
  cmd_t       f_cmd;
  logic       q_valid, q_ready;
  cmd_t       q_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      prg_banks_16k <= PRG_BANKS_RESET;
      has_prg_ram   <= 1'b1;
      four_screen   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PRG_BANKS:   prg_banks_16k <= cfg_data[5:0];
        CFG_HAS_PRG_RAM: has_prg_ram   <= cfg_data[0];
        CFG_FOUR_SCREEN: four_screen   <= cfg_data[0];
        default:         four_screen   <= four_screen;
      endcase
    end
  end

  bsm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  bsm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  bsm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .prg_banks_16k (prg_banks_16k),
    .has_prg_ram   (has_prg_ram),
    .four_screen   (four_screen),
    .cmd_valid     (q_valid),
    .cmd_ready     (q_ready),
    .cmd           (q_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data)
  );

endmodule
`default_nettype wire

FILE: rtl/bsm_front.sv
`default_nettype none
module bsm_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bsm_pkg::in_t  in_data,
  output logic               cmd_valid,
  input  wire logic          cmd_ready,
  output bsm_pkg::cmd_t      cmd
);
  import bsm_pkg::*;

  cmd_t cmd_next;
  logic odd;

  assign in_ready = !cmd_valid || cmd_ready;
  assign odd = in_data.address[0];

  always_comb begin
    cmd_next.op      = req_t'(in_data.req_type);
    cmd_next.wr      = WR_NONE;
    cmd_next.slot    = 3'd0;
    cmd_next.prg_win = in_data.address[15];
    cmd_next.ram_win = (in_data.address[15:13] == 3'b011);
    cmd_next.value   = in_data.value;
    cmd_next.clocks  = in_data.counter_clocks;
    case (req_t'(in_data.req_type))
      REQ_WRITE: begin
        if (in_data.address[15]) begin
          case (in_data.address[14:13])
            2'd0:    cmd_next.wr = odd ? WR_BANK_DATA : WR_BANK_SEL;
            2'd1:    cmd_next.wr = odd ? WR_NONE : WR_MIRROR;
            2'd2:    cmd_next.wr = odd ? WR_RELOAD : WR_RELOAD_VAL;
            default: cmd_next.wr = odd ? WR_IRQ_ON : WR_IRQ_OFF;
          endcase
        end
      end
      REQ_CPU_XLAT: cmd_next.slot = {1'b0, in_data.address[14:13]};
      REQ_PAT_XLAT: cmd_next.slot = in_data.address[12:10];
      default:      cmd_next.slot = 3'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= cmd_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bsm_queue.sv
`default_nettype none
module bsm_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire bsm_pkg::cmd_t  push_cmd,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output bsm_pkg::cmd_t       pop_cmd
);
  import bsm_pkg::*;

  cmd_t                mem [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bsm_back.sv
`default_nettype none
module bsm_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [5:0]     prg_banks_16k,
  input  wire logic           has_prg_ram,
  input  wire logic           four_screen,
  input  wire logic           cmd_valid,
  output logic                cmd_ready,
  input  wire bsm_pkg::cmd_t  cmd,
  output logic                out_valid,
  input  wire logic           out_ready,
  output bsm_pkg::out_t       out_data
);
  import bsm_pkg::*;

  bk_state_t   state, state_next;
  logic [2:0]  remain, remain_next;
  logic [7:0]  bank_select, bank_select_next;
  logic [7:0]  bank_regs [8];
  logic [7:0]  irq_reload_value, irq_reload_value_next;
  logic [7:0]  irq_counter, irq_counter_next;
  logic        reload_pending, reload_pending_next;
  logic        irq_enabled, irq_enabled_next;
  logic        irq_pending, irq_pending_next;
  logic        mirror_state, mirror_state_next;
  logic        bank_we;

  logic        out_free;
  logic        emit;
  out_t        result;

  logic [5:0]  units;
  logic [6:0]  n8;
  logic [6:0]  prg_mask;
  logic [7:0]  prg_r6;
  logic [7:0]  prg_bank;
  logic [2:0]  chr_slot;
  logic [7:0]  chr_bank;

  assign out_free = !out_valid || out_ready;

  // Program bank lookup
  always_comb begin
    units    = (prg_banks_16k == 6'd0) ? 6'd1 : prg_banks_16k;
    n8       = {units, 1'b0};
    prg_mask = n8 - 7'd1;
    prg_r6   = bank_regs[6] & {1'b0, prg_mask};
    case (cmd.slot[1:0])
      2'd0:    prg_bank = bank_select[6] ? {1'b0, n8 - 7'd2} : prg_r6;
      2'd1:    prg_bank = bank_regs[7] & {1'b0, prg_mask};
      2'd2:    prg_bank = bank_select[6] ? prg_r6 : {1'b0, n8 - 7'd2};
      default: prg_bank = {1'b0, prg_mask};
    endcase
  end

  // Pattern bank lookup; bit 7 of bank_select swaps the halves
  always_comb begin
    chr_slot = cmd.slot ^ {bank_select[7], 2'b00};
    case (chr_slot[2:1])
      2'd0:    chr_bank = {bank_regs[0][7:1], chr_slot[0]};
      2'd1:    chr_bank = {bank_regs[1][7:1], chr_slot[0]};
      default: chr_bank = bank_regs[chr_slot - 3'd2];
    endcase
  end

  always_comb begin
    state_next            = state;
    remain_next           = remain;
    bank_select_next      = bank_select;
    irq_reload_value_next = irq_reload_value;
    irq_counter_next      = irq_counter;
    reload_pending_next   = reload_pending;
    irq_enabled_next      = irq_enabled;
    irq_pending_next      = irq_pending;
    mirror_state_next     = mirror_state;
    bank_we               = 1'b0;
    cmd_ready             = 1'b0;
    emit                  = 1'b0;
    case (state)
      BK_IDLE: begin
        cmd_ready = (cmd.op == REQ_TICK) || out_free;
        if (cmd_valid && cmd_ready) begin
          if (cmd.op == REQ_TICK) begin
            state_next  = BK_TICK;
            remain_next = cmd.clocks;
          end else begin
            emit = 1'b1;
            if (cmd.op == REQ_WRITE) begin
              case (cmd.wr)
                WR_BANK_SEL:   bank_select_next = cmd.value;
                WR_BANK_DATA:  bank_we = 1'b1;
                WR_MIRROR:     if (!four_screen) mirror_state_next = cmd.value[0];
                WR_RELOAD_VAL: irq_reload_value_next = cmd.value;
                WR_RELOAD:     reload_pending_next = 1'b1;
                WR_IRQ_OFF: begin
                  irq_enabled_next = 1'b0;
                  irq_pending_next = 1'b0;
                end
                WR_IRQ_ON:     irq_enabled_next = 1'b1;
                default:       bank_we = 1'b0;
              endcase
            end
          end
        end
      end
      BK_TICK: begin
        if (remain != 3'd0) begin
          // one counter clock per cycle
          remain_next = remain - 3'd1;
          if (reload_pending || irq_counter == 8'd0) begin
            irq_counter_next    = irq_reload_value;
            reload_pending_next = 1'b0;
            if (!reload_pending && irq_reload_value == 8'd0 && irq_enabled) begin
              irq_pending_next = 1'b1;
            end
          end else begin
            irq_counter_next = irq_counter - 8'd1;
            if (irq_counter == 8'd1 && irq_enabled) begin
              irq_pending_next = 1'b1;
            end
          end
        end else if (out_free) begin
          emit       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    result.bank_number       = 8'd0;
    result.in_prg_ram        = 1'b0;
    result.mirror_horizontal = mirror_state_next;
    result.irq_line          = irq_pending_next;
    if (state == BK_IDLE) begin
      case (cmd.op)
        REQ_CPU_XLAT: begin
          result.bank_number = cmd.prg_win ? prg_bank : 8'd0;
          result.in_prg_ram  = cmd.ram_win && has_prg_ram;
        end
        REQ_PAT_XLAT: result.bank_number = chr_bank;
        default:      result.bank_number = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= BK_IDLE;
      remain           <= 3'd0;
      bank_select      <= 8'd0;
      irq_reload_value <= 8'd0;
      irq_counter      <= 8'd0;
      reload_pending   <= 1'b0;
      irq_enabled      <= 1'b0;
      irq_pending      <= 1'b0;
      mirror_state     <= 1'b0;
      out_valid        <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        bank_regs[i] <= 8'd0;
      end
    end else begin
      state            <= state_next;
      remain           <= remain_next;
      bank_select      <= bank_select_next;
      irq_reload_value <= irq_reload_value_next;
      irq_counter      <= irq_counter_next;
      reload_pending   <= reload_pending_next;
      irq_enabled      <= irq_enabled_next;
      irq_pending      <= irq_pending_next;
      mirror_state     <= mirror_state_next;
      if (bank_we) begin
        bank_regs[bank_select[2:0]] <= cmd.value;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= result;
    end
  end

endmodule
`default_nettype wire
